// ----- hw/rtl/dhtd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dhtd_pkg
// Types and constants shared by the single-wire sensor edge timing decoder.
// ----------------------------------------------------------------------------
package dhtd_pkg;

    localparam int TIME_W   = 32;
    localparam int LIMIT_W  = 16;
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 3;
    localparam int CFG_IDX_W = 3;

    localparam int NUM_BYTES = 5;
    localparam logic [2:0] LAST_BYTE = 3'd4;
    localparam logic [2:0] TOP_BIT   = 3'd7;

    // Register reset values, in microseconds
    localparam logic [LIMIT_W-1:0] TIMEOUT_RST   = 16'd6000;
    localparam logic [LIMIT_W-1:0] GLITCH_RST    = 16'd25;
    localparam logic [LIMIT_W-1:0] RESP_LOW_RST  = 16'd125;
    localparam logic [LIMIT_W-1:0] RESP_HIGH_RST = 16'd190;
    localparam logic [LIMIT_W-1:0] SHORT_RST     = 16'd10;
    localparam logic [LIMIT_W-1:0] BIT_LOW_RST   = 16'd60;
    localparam logic [LIMIT_W-1:0] BIT_HIGH_RST  = 16'd155;
    localparam logic [LIMIT_W-1:0] ONE_THR_RST   = 16'd90;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TIMEOUT   = 3'd0,
        CFG_GLITCH    = 3'd1,
        CFG_RESP_LOW  = 3'd2,
        CFG_RESP_HIGH = 3'd3,
        CFG_SHORT     = 3'd4,
        CFG_BIT_LOW   = 3'd5,
        CFG_BIT_HIGH  = 3'd6,
        CFG_ONE_THR   = 3'd7
    } cfg_idx_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_NOTSTART = 3'd1,
        ST_TIMEOUT  = 3'd2,
        ST_SHORT    = 3'd3,
        ST_CHECKSUM = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        PH_STOPPED  = 4'b0001,
        PH_RESPONSE = 4'b0010,
        PH_DATA     = 4'b0100,
        PH_ACQUIRED = 4'b1000
    } phase_t;

    // Classified request passed from the front to the execution stage
    typedef struct packed {
        logic              is_start;
        logic [TIME_W-1:0] time_us;
    } req_t;

    localparam int REQ_W = $bits(req_t);

    typedef struct packed {
        logic [BYTE_W-1:0]   temperature;
        logic [BYTE_W-1:0]   humidity;
        logic [STATUS_W-1:0] result_status;
        logic                finished;
        logic                busy_res;
        logic                start_refused;
    } res_t;

    localparam int RES_W   = $bits(res_t);
    localparam int TDATA_W = ((RES_W + 7) / 8) * 8;

endpackage

`default_nettype wire

// ----- hw/rtl/dhtd_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dhtd_front
// Input stage: accepts stream requests, tags them as start or edge and
// holds one classified request for the queue.
// ----------------------------------------------------------------------------
module dhtd_front (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [31:0]          s_tdata,
    input  wire logic [0:0]           s_tuser,
    output logic                      req_valid,
    input  wire logic                 req_ready,
    output dhtd_pkg::req_t            req
);

    logic           valid_reg;
    logic           valid_next;
    dhtd_pkg::req_t req_reg;
    logic           take;

    assign s_tready = !valid_reg || req_ready;
    assign take     = s_tvalid && s_tready;

    always_comb begin
        valid_next = valid_reg;
        if (take) begin
            valid_next = 1'b1;
        end else if (req_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // action 0 is a start request, 1 a falling edge
    always_ff @(posedge aclk) begin
        if (take) begin
            req_reg.is_start <= !s_tuser[0];
            req_reg.time_us  <= s_tdata;
        end
    end

    assign req_valid = valid_reg;
    assign req       = req_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/dhtd_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dhtd_queue
// Short FIFO of classified requests between the front and the execution
// stage, so each side can stall on its own.
// ----------------------------------------------------------------------------
module dhtd_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push_valid,
    output logic                push_ready,
    input  wire dhtd_pkg::req_t push_req,
    output logic                pop_valid,
    input  wire logic           pop_ready,
    output dhtd_pkg::req_t      pop_req
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    dhtd_pkg::req_t   mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign push_ready = (count_reg != CNT_FULL);
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_req    = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_req;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/dhtd_exec.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dhtd_exec
// Execution stage: holds the timing limits and the acquisition state,
// measures each edge gap, shifts in data bits and registers one result per
// request.
// ----------------------------------------------------------------------------
module dhtd_exec (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_we,
    input  wire logic [dhtd_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  wire logic [dhtd_pkg::LIMIT_W-1:0]     cfg_wdata,
    input  wire logic                             req_valid,
    output logic                                  req_ready,
    input  wire dhtd_pkg::req_t                   req,
    output logic                                  res_valid,
    input  wire logic                             res_ready,
    output dhtd_pkg::res_t                        res
);

    localparam int TW = dhtd_pkg::TIME_W;
    localparam int LW = dhtd_pkg::LIMIT_W;
    localparam int BW = dhtd_pkg::BYTE_W;

    // Timing limits
    logic [LW-1:0] timeout_reg, glitch_reg, resp_low_reg, resp_high_reg;
    logic [LW-1:0] short_reg, bit_low_reg, bit_high_reg, one_thr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg   <= dhtd_pkg::TIMEOUT_RST;
            glitch_reg    <= dhtd_pkg::GLITCH_RST;
            resp_low_reg  <= dhtd_pkg::RESP_LOW_RST;
            resp_high_reg <= dhtd_pkg::RESP_HIGH_RST;
            short_reg     <= dhtd_pkg::SHORT_RST;
            bit_low_reg   <= dhtd_pkg::BIT_LOW_RST;
            bit_high_reg  <= dhtd_pkg::BIT_HIGH_RST;
            one_thr_reg   <= dhtd_pkg::ONE_THR_RST;
        end else if (cfg_we) begin
            case (dhtd_pkg::cfg_idx_t'(cfg_addr))
                dhtd_pkg::CFG_TIMEOUT:   timeout_reg   <= cfg_wdata;
                dhtd_pkg::CFG_GLITCH:    glitch_reg    <= cfg_wdata;
                dhtd_pkg::CFG_RESP_LOW:  resp_low_reg  <= cfg_wdata;
                dhtd_pkg::CFG_RESP_HIGH: resp_high_reg <= cfg_wdata;
                dhtd_pkg::CFG_SHORT:     short_reg     <= cfg_wdata;
                dhtd_pkg::CFG_BIT_LOW:   bit_low_reg   <= cfg_wdata;
                dhtd_pkg::CFG_BIT_HIGH:  bit_high_reg  <= cfg_wdata;
                dhtd_pkg::CFG_ONE_THR:   one_thr_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Acquisition state
    dhtd_pkg::phase_t  phase_reg, phase_next;
    logic [TW-1:0]     last_time_reg, last_time_next;
    logic [BW-1:0]     bytes_reg [dhtd_pkg::NUM_BYTES];
    logic [BW-1:0]     bytes_next [dhtd_pkg::NUM_BYTES];
    logic [2:0]        bit_pos_reg, bit_pos_next;
    logic [2:0]        byte_idx_reg, byte_idx_next;
    dhtd_pkg::status_t status_reg, status_next;
    logic [BW-1:0]     hum_reg, hum_next;
    logic [BW-1:0]     temp_reg, temp_next;

    logic              out_valid_reg;
    dhtd_pkg::res_t    out_reg;

    logic              pop;
    logic [TW-1:0]     gap;
    logic [2:0]        idx_c;
    logic              bit_one;
    logic [BW-1:0]     sum8;
    logic              refused;
    logic              done;
    logic              active;

    assign req_ready = !out_valid_reg || res_ready;
    assign pop       = req_valid && req_ready;
    assign gap       = req.time_us - last_time_reg;
    assign active    = (phase_reg == dhtd_pkg::PH_RESPONSE) ||
                       (phase_reg == dhtd_pkg::PH_DATA);
    assign idx_c     = (byte_idx_reg < 3'(dhtd_pkg::NUM_BYTES)) ?
                       byte_idx_reg : dhtd_pkg::LAST_BYTE;
    assign bit_one   = gap > {{(TW-LW){1'b0}}, one_thr_reg};

    always_comb begin
        phase_next     = phase_reg;
        last_time_next = last_time_reg;
        bytes_next     = bytes_reg;
        bit_pos_next   = bit_pos_reg;
        byte_idx_next  = byte_idx_reg;
        status_next    = status_reg;
        hum_next       = hum_reg;
        temp_next      = temp_reg;
        refused        = 1'b0;
        done           = 1'b0;
        sum8           = '0;
        if (pop) begin
            if (req.is_start) begin
                if (!active) begin
                    phase_next     = dhtd_pkg::PH_RESPONSE;
                    last_time_next = req.time_us;
                    for (int i = 0; i < dhtd_pkg::NUM_BYTES; i++) begin
                        bytes_next[i] = '0;
                    end
                    bit_pos_next   = dhtd_pkg::TOP_BIT;
                    byte_idx_next  = '0;
                    hum_next       = '0;
                    temp_next      = '0;
                end else begin
                    refused = 1'b1;
                end
            end else if (active) begin
                last_time_next = req.time_us;
                if (gap > {{(TW-LW){1'b0}}, timeout_reg}) begin
                    status_next = dhtd_pkg::ST_TIMEOUT;
                    phase_next  = dhtd_pkg::PH_STOPPED;
                    done        = 1'b1;
                end else if (phase_reg == dhtd_pkg::PH_RESPONSE) begin
                    if (gap < {{(TW-LW){1'b0}}, glitch_reg}) begin
                        // glitch: keep measuring from the previous edge
                        last_time_next = last_time_reg;
                    end else if (gap > {{(TW-LW){1'b0}}, resp_low_reg} &&
                                 gap < {{(TW-LW){1'b0}}, resp_high_reg}) begin
                        phase_next = dhtd_pkg::PH_DATA;
                    end else begin
                        status_next = dhtd_pkg::ST_TIMEOUT;
                        phase_next  = dhtd_pkg::PH_STOPPED;
                        done        = 1'b1;
                    end
                end else begin
                    if (gap < {{(TW-LW){1'b0}}, short_reg}) begin
                        status_next = dhtd_pkg::ST_SHORT;
                        phase_next  = dhtd_pkg::PH_STOPPED;
                        done        = 1'b1;
                    end else if (gap > {{(TW-LW){1'b0}}, bit_low_reg} &&
                                 gap < {{(TW-LW){1'b0}}, bit_high_reg}) begin
                        for (int i = 0; i < dhtd_pkg::NUM_BYTES; i++) begin
                            if (bit_one && (idx_c == 3'(i))) begin
                                bytes_next[i] = bytes_reg[i] | (BW'(1) << bit_pos_reg);
                            end
                        end
                        if (bit_pos_reg != '0) begin
                            bit_pos_next = bit_pos_reg - 1'b1;
                        end else begin
                            bit_pos_next = dhtd_pkg::TOP_BIT;
                            if (idx_c < dhtd_pkg::LAST_BYTE) begin
                                byte_idx_next = idx_c + 1'b1;
                            end else begin
                                // last bit: latch readings and verify checksum
                                hum_next  = bytes_next[0];
                                temp_next = bytes_next[2];
                                sum8      = BW'(bytes_next[0] + bytes_next[2]);
                                done      = 1'b1;
                                if (bytes_next[4] == sum8) begin
                                    status_next = dhtd_pkg::ST_OK;
                                    phase_next  = dhtd_pkg::PH_ACQUIRED;
                                end else begin
                                    status_next = dhtd_pkg::ST_CHECKSUM;
                                    phase_next  = dhtd_pkg::PH_STOPPED;
                                end
                            end
                        end
                    end else begin
                        status_next = dhtd_pkg::ST_TIMEOUT;
                        phase_next  = dhtd_pkg::PH_STOPPED;
                        done        = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= dhtd_pkg::PH_STOPPED;
            last_time_reg <= '0;
            for (int i = 0; i < dhtd_pkg::NUM_BYTES; i++) begin
                bytes_reg[i] <= '0;
            end
            bit_pos_reg   <= dhtd_pkg::TOP_BIT;
            byte_idx_reg  <= '0;
            status_reg    <= dhtd_pkg::ST_NOTSTART;
            hum_reg       <= '0;
            temp_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            last_time_reg <= last_time_next;
            bytes_reg     <= bytes_next;
            bit_pos_reg   <= bit_pos_next;
            byte_idx_reg  <= byte_idx_next;
            status_reg    <= status_next;
            hum_reg       <= hum_next;
            temp_reg      <= temp_next;
            if (pop) begin
                out_valid_reg <= 1'b1;
            end else if (res_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            out_reg.start_refused <= refused;
            out_reg.busy_res      <= (phase_next == dhtd_pkg::PH_RESPONSE) ||
                                     (phase_next == dhtd_pkg::PH_DATA);
            out_reg.finished      <= done;
            out_reg.result_status <= status_next;
            out_reg.humidity      <= hum_next;
            out_reg.temperature   <= temp_next;
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/dht11_edge_timing_decoder_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dht11_edge_timing_decoder_core
// Decodes a single-wire humidity/temperature sensor reply from timestamped
// falling edges and start requests.
// ----------------------------------------------------------------------------
// Every request gives exactly one result. The block sustains one request per
// clock while the result side is ready. On the fastest path a request passes
// the input register, the request queue and the result register, and the
// result can be taken at the following edge. The execution stage sets the
// rate: it does the gap subtract, the limit compares and the bit insert for a
// request in the logic ahead of the result register. A queue of QUEUE_DEPTH
// requests sits between the input register and the execution stage, so input
// and output stall independently. The user must write limits through the cfg
// port only while no request is in flight; the block does not enforce this.
// ----------------------------------------------------------------------------
module dht11_edge_timing_decoder_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // Configuration
    input  wire logic                                cfg_we,
    input  wire logic [dhtd_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  wire logic [dhtd_pkg::LIMIT_W-1:0]        cfg_wdata,
    // Requests
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [31:0]                         s_tdata,   // [31:0] time_us
    input  wire logic [0:0]                          s_tuser,   // [0] action
    // Results
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // [0] start_refused, [1] busy_res, [2] finished, [5:3] result_status,
    // [13:6] humidity, [21:14] temperature, upper bits zero
    output logic [dhtd_pkg::TDATA_W-1:0]             m_tdata
);

    logic           fr_valid, fr_ready;
    dhtd_pkg::req_t fr_req;
    logic           q_valid, q_ready;
    dhtd_pkg::req_t q_req;
    dhtd_pkg::res_t res;

    dhtd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .req_valid (fr_valid),
        .req_ready (fr_ready),
        .req       (fr_req)
    );

    dhtd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (fr_valid),
        .push_ready (fr_ready),
        .push_req   (fr_req),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_req    (q_req)
    );

    dhtd_exec u_exec (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .req_valid (q_valid),
        .req_ready (q_ready),
        .req       (q_req),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    assign m_tdata = {{(dhtd_pkg::TDATA_W - dhtd_pkg::RES_W){1'b0}}, res};

    // A finished acquisition is never reported as still busy
    a_finished_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2] |-> !m_tdata[1])
        else $error("finished result reports busy");

    // A refused start only happens mid-acquisition and ends nothing
    a_refused_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> m_tdata[1] && !m_tdata[2])
        else $error("refused start outside an acquisition");

    // The result status is always one of the defined codes
    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[5:3] == dhtd_pkg::ST_OK ||
                      m_tdata[5:3] == dhtd_pkg::ST_NOTSTART ||
                      m_tdata[5:3] == dhtd_pkg::ST_TIMEOUT ||
                      m_tdata[5:3] == dhtd_pkg::ST_SHORT ||
                      m_tdata[5:3] == dhtd_pkg::ST_CHECKSUM))
        else $error("result status out of range");

    // A request held by the front is not lost while the queue is full
    a_front_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        fr_valid && !fr_ready |=> fr_valid && $stable(fr_req))
        else $error("front dropped a stalled request");

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the sensor edge timing decoder. Start and edge requests go
// into the slave stream and an in-bench decoder predicts each result. Results
// are checked in order, field by field. The run has short directed cases at
// the window boundaries, then randomized sensor frames with faults, refused
// starts and stray edges mixed in. The limit set changes between phases,
// including the all-zero and all-ones settings.
// ----------------------------------------------------------------------------
module tb_top;
    import dhtd_pkg::*;

    localparam bit ACT_START = 1'b0;
    localparam bit ACT_EDGE  = 1'b1;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int REPORT_MAX = 10;

    typedef bit [LIMIT_W-1:0] limit_set_t [8];

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr = '0;
    logic [LIMIT_W-1:0]   cfg_wdata = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [31:0]          s_tdata = '0;   // [31:0] time_us
    logic [0:0]           s_tuser = '0;   // [0] action
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // [0] start_refused, [1] busy_res, [2] finished, [5:3] result_status,
    // [13:6] humidity, [21:14] temperature, upper bits zero
    logic [TDATA_W-1:0]   m_tdata;

    // Decoder copy kept by the bench
    limit_set_t  dec_limits;
    phase_t      dec_phase;
    bit [31:0]   dec_mark;
    bit [7:0]    dec_bytes [NUM_BYTES];
    bit [2:0]    dec_bitpos;
    bit [2:0]    dec_byteidx;
    status_t     dec_status;
    bit [7:0]    dec_hum;
    bit [7:0]    dec_temp;

    res_t        pending_reports [$];
    int unsigned decoded_items = 0;
    int unsigned report_errors = 0;
    bit [31:0]   sensor_clock = 32'h0;
    bit          tx_eager = 1'b0;
    bit          rx_eager = 1'b0;

    dht11_edge_timing_decoder_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic void halt_decode(status_t code);
        dec_status = code;
        dec_phase  = PH_STOPPED;
    endfunction

    function automatic res_t decode_event(bit act, bit [31:0] now);
        res_t      r;
        bit [31:0] gap;
        bit [2:0]  slot;
        bit [7:0]  sum;
        r = '0;
        if (act == ACT_START) begin
            decoded_items++;
            if (dec_phase == PH_STOPPED || dec_phase == PH_ACQUIRED) begin
                dec_phase   = PH_RESPONSE;
                dec_bytes   = '{default: 8'h00};
                dec_bitpos  = TOP_BIT;
                dec_byteidx = '0;
                dec_hum     = '0;
                dec_temp    = '0;
                dec_mark    = now;
            end else begin
                r.start_refused = 1'b1;
            end
        end else if (dec_phase == PH_RESPONSE || dec_phase == PH_DATA) begin
            decoded_items++;
            gap = now - dec_mark;
            dec_mark = now;
            if (gap > dec_limits[CFG_TIMEOUT]) begin
                halt_decode(ST_TIMEOUT);
                r.finished = 1'b1;
            end else if (dec_phase == PH_RESPONSE) begin
                if (gap < dec_limits[CFG_GLITCH]) begin
                    // glitch: keep the previous edge time
                    dec_mark = now - gap;
                end else if (gap > dec_limits[CFG_RESP_LOW] &&
                             gap < dec_limits[CFG_RESP_HIGH]) begin
                    dec_phase = PH_DATA;
                end else begin
                    halt_decode(ST_TIMEOUT);
                    r.finished = 1'b1;
                end
            end else if (gap < dec_limits[CFG_SHORT]) begin
                halt_decode(ST_SHORT);
                r.finished = 1'b1;
            end else if (gap > dec_limits[CFG_BIT_LOW] && gap < dec_limits[CFG_BIT_HIGH]) begin
                slot = (dec_byteidx < NUM_BYTES) ? dec_byteidx : LAST_BYTE;
                if (gap > dec_limits[CFG_ONE_THR]) begin
                    dec_bytes[slot][dec_bitpos] = 1'b1;
                end
                if (dec_bitpos != 0) begin
                    dec_bitpos--;
                end else begin
                    dec_bitpos = TOP_BIT;
                    if (slot < LAST_BYTE) begin
                        dec_byteidx = 3'(slot + 1);
                    end else begin
                        dec_hum  = dec_bytes[0];
                        dec_temp = dec_bytes[2];
                        sum = dec_bytes[0] + dec_bytes[2];
                        r.finished = 1'b1;
                        if (dec_bytes[4] == sum) begin
                            dec_status = ST_OK;
                            dec_phase  = PH_ACQUIRED;
                        end else begin
                            halt_decode(ST_CHECKSUM);
                        end
                    end
                end
            end else begin
                halt_decode(ST_TIMEOUT);
                r.finished = 1'b1;
            end
        end
        r.busy_res      = (dec_phase == PH_RESPONSE || dec_phase == PH_DATA);
        r.result_status = dec_status;
        r.humidity      = dec_hum;
        r.temperature   = dec_temp;
        return r;
    endfunction

    task automatic send_req(bit act, bit [31:0] now);
        int unsigned pause;
        pause = tx_eager ? 0 : $urandom_range(0, 4);
        if (pause != 0) begin
            s_tvalid <= 1'b0;
            repeat (pause) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= now;
        do @(posedge aclk); while (s_tready !== 1'b1);
        pending_reports.push_back(decode_event(act, now));
    endtask

    // Drop valid and wait until every result is back before touching limits
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic load_limits(limit_set_t v);
        settle();
        for (int i = 0; i < 8; i++) begin
            cfg_we    <= 1'b1;
            cfg_addr  <= cfg_idx_t'(i);
            cfg_wdata <= v[i];
            @(posedge aclk);
            dec_limits[i] = v[i];
        end
        cfg_we <= 1'b0;
    endtask

    function automatic limit_set_t sane_limits();
        limit_set_t v;
        bit [15:0]  top;
        v[CFG_GLITCH]    = $urandom_range(1, 40);
        v[CFG_RESP_LOW]  = v[CFG_GLITCH] + $urandom_range(0, 100);
        v[CFG_RESP_HIGH] = v[CFG_RESP_LOW] + $urandom_range(2, 100);
        v[CFG_SHORT]     = $urandom_range(0, 30);
        v[CFG_BIT_LOW]   = v[CFG_SHORT] + $urandom_range(0, 40);
        v[CFG_ONE_THR]   = v[CFG_BIT_LOW] + $urandom_range(1, 60);
        v[CFG_BIT_HIGH]  = v[CFG_ONE_THR] + $urandom_range(2, 80);
        top = (v[CFG_RESP_HIGH] > v[CFG_BIT_HIGH]) ? v[CFG_RESP_HIGH] : v[CFG_BIT_HIGH];
        v[CFG_TIMEOUT]   = top + ($urandom_range(0, 1) ? 0 : $urandom_range(0, 3000));
        return v;
    endfunction

    function automatic bit [7:0] pick_byte();
        case ($urandom_range(0, 3))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom());
        endcase
    endfunction

    // Gap that ends the acquisition with an error
    function automatic bit [31:0] fault_gap(bit in_response);
        bit [31:0] tmo;
        tmo = dec_limits[CFG_TIMEOUT];
        case ($urandom_range(0, 2))
            0: return tmo + 1 + ($urandom_range(0, 1) ? $urandom_range(0, 1000)
                                                      : $urandom_range(0, 32'hFFF0_0000));
            1: begin
                if (in_response)
                    return $urandom_range(0, 1) ? dec_limits[CFG_RESP_LOW]
                                                : dec_limits[CFG_RESP_HIGH];
                return $urandom_range(0, 1) ? dec_limits[CFG_BIT_LOW] : dec_limits[CFG_BIT_HIGH];
            end
            default: begin
                if (in_response)
                    return dec_limits[CFG_GLITCH];
                if (dec_limits[CFG_SHORT] == 0)
                    return dec_limits[CFG_BIT_HIGH];
                return $urandom_range(0, dec_limits[CFG_SHORT] - 1);
            end
        endcase
    endfunction

    // One sensor reply: start, response, forty bits, with optional damage
    task automatic run_frame();
        bit [7:0]  b [5];
        bit [31:0] mark;
        int        fault_at;
        int        refuse_at;
        bit        val;
        foreach (b[i]) b[i] = pick_byte();
        b[4] = b[0] + b[2];
        if ($urandom_range(0, 4) == 0) b[4] = b[4] ^ (8'h01 << $urandom_range(0, 7));
        fault_at  = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 40) : -1;
        refuse_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : -1;
        tx_eager  = ($urandom_range(0, 3) == 0);
        rx_eager  = ($urandom_range(0, 3) == 0);
        sensor_clock += $urandom_range(1, 100000);
        mark = sensor_clock;
        send_req(ACT_START, mark);
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 2))
                send_req(ACT_EDGE, mark + $urandom_range(0, dec_limits[CFG_GLITCH] - 1));
        end
        for (int k = 0; k <= 40; k++) begin
            if (k == refuse_at) send_req(ACT_START, $urandom());
            if (k == fault_at) begin
                mark += fault_gap(k == 0);
                send_req(ACT_EDGE, mark);
                break;
            end
            if (k == 0) begin
                mark += $urandom_range(dec_limits[CFG_RESP_LOW] + 1, dec_limits[CFG_RESP_HIGH] - 1);
            end else begin
                val = b[(k - 1) / 8][7 - ((k - 1) % 8)];
                if (val)
                    mark += $urandom_range(dec_limits[CFG_ONE_THR] + 1,
                                           dec_limits[CFG_BIT_HIGH] - 1);
                else
                    mark += $urandom_range(dec_limits[CFG_BIT_LOW] + 1, dec_limits[CFG_ONE_THR]);
            end
            send_req(ACT_EDGE, mark);
        end
        sensor_clock = mark;
    endtask

    task automatic send_noise();
        bit [31:0] t;
        t = $urandom_range(0, 1) ? $urandom() : sensor_clock + $urandom_range(0, 400);
        sensor_clock = t;
        send_req(1'($urandom_range(0, 1)), t);
    endtask

    task automatic test_idle_and_refusal();
        bit [31:0] t0;
        send_req(ACT_EDGE, 32'hFFFF_FFFF);
        send_req(ACT_EDGE, 32'h0000_0000);
        t0 = 32'hFFFF_FFF0;
        send_req(ACT_START, t0);
        send_req(ACT_START, t0 + 3);
        send_req(ACT_EDGE, t0 + dec_limits[CFG_GLITCH] - 1);
        // response gap wraps past zero
        t0 = t0 + dec_limits[CFG_RESP_LOW] + 1;
        send_req(ACT_EDGE, t0);
        send_req(ACT_START, 32'h0000_0000);
        send_req(ACT_EDGE, t0 + dec_limits[CFG_SHORT] - 1);
        send_req(ACT_EDGE, 32'h1234_5678);
    endtask

    task automatic test_response_window();
        bit [31:0] gaps [4];
        bit [31:0] t0;
        gaps[0] = dec_limits[CFG_RESP_LOW];
        gaps[1] = dec_limits[CFG_RESP_HIGH];
        gaps[2] = dec_limits[CFG_TIMEOUT] + 1;
        gaps[3] = dec_limits[CFG_GLITCH];
        foreach (gaps[i]) begin
            t0 = $urandom();
            send_req(ACT_START, t0);
            send_req(ACT_EDGE, t0 + gaps[i]);
        end
    endtask

    task automatic test_data_window();
        bit [31:0] gaps [4];
        bit [31:0] t0;
        gaps[0] = dec_limits[CFG_BIT_LOW];
        gaps[1] = dec_limits[CFG_BIT_HIGH];
        gaps[2] = dec_limits[CFG_SHORT] - 1;
        gaps[3] = 32'hFFFF_FFFF;
        foreach (gaps[i]) begin
            t0 = $urandom();
            send_req(ACT_START, t0);
            t0 = t0 + dec_limits[CFG_RESP_LOW] + 1;
            send_req(ACT_EDGE, t0);
            send_req(ACT_EDGE, t0 + gaps[i]);
        end
    endtask

    task automatic test_extreme_limits();
        limit_set_t v;
        bit [31:0]  t0;
        v = '{default: 16'h0000};
        load_limits(v);
        t0 = $urandom();
        send_req(ACT_START, t0);
        send_req(ACT_EDGE, t0);
        send_req(ACT_START, t0);
        send_req(ACT_EDGE, t0 + 1);
        repeat (20) send_noise();
        v = '{default: 16'hFFFF};
        load_limits(v);
        t0 = $urandom();
        send_req(ACT_START, t0);
        send_req(ACT_EDGE, t0 + 1);
        send_req(ACT_EDGE, t0 + 32'h0000_FFFF);
        send_req(ACT_START, t0);
        send_req(ACT_EDGE, t0 + 32'h0001_0000);
        repeat (20) send_noise();
    endtask

    task automatic test_random_frames(int unsigned goal, bit reset_values);
        limit_set_t  v;
        int unsigned first;
        if (reset_values) begin
            v[CFG_TIMEOUT]   = TIMEOUT_RST;
            v[CFG_GLITCH]    = GLITCH_RST;
            v[CFG_RESP_LOW]  = RESP_LOW_RST;
            v[CFG_RESP_HIGH] = RESP_HIGH_RST;
            v[CFG_SHORT]     = SHORT_RST;
            v[CFG_BIT_LOW]   = BIT_LOW_RST;
            v[CFG_BIT_HIGH]  = BIT_HIGH_RST;
            v[CFG_ONE_THR]   = ONE_THR_RST;
        end else begin
            v = sane_limits();
        end
        load_limits(v);
        first = decoded_items;
        while (decoded_items - first < goal) begin
            if ($urandom_range(0, 9) < 7) begin
                run_frame();
            end else begin
                tx_eager = 1'b0;
                rx_eager = 1'b0;
                repeat ($urandom_range(1, 4)) send_noise();
            end
        end
    endtask

    // Result side: random stalls, in-order compare
    initial begin : result_check
        res_t        got;
        res_t        want;
        int unsigned pause;
        wait (aresetn === 1'b1);
        forever begin
            pause = rx_eager ? 0 : $urandom_range(0, 4);
            if (pause != 0) begin
                m_tready <= 1'b0;
                repeat (pause) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
            got = res_t'(m_tdata[RES_W-1:0]);
            if (pending_reports.size() == 0) begin
                report_errors++;
                if (report_errors <= REPORT_MAX)
                    $display("error: result %h arrived with nothing expected", m_tdata);
            end else begin
                want = pending_reports.pop_front();
                if (got.start_refused !== want.start_refused ||
                    got.busy_res !== want.busy_res ||
                    got.finished !== want.finished ||
                    got.result_status !== want.result_status ||
                    got.humidity !== want.humidity ||
                    got.temperature !== want.temperature ||
                    m_tdata[TDATA_W-1:RES_W] !== '0) begin
                    report_errors++;
                    if (report_errors <= REPORT_MAX) begin
                        $display("error: exp refused=%0b busy=%0b fin=%0b st=%0d hum=%0d temp=%0d",
                                 want.start_refused, want.busy_res, want.finished,
                                 want.result_status, want.humidity, want.temperature);
                        $display("       got refused=%0b busy=%0b fin=%0b st=%0d hum=%0d temp=%0d pad=%0b",
                                 got.start_refused, got.busy_res, got.finished,
                                 got.result_status, got.humidity, got.temperature,
                                 m_tdata[TDATA_W-1:RES_W]);
                    end
                end
            end
        end
    end

    // Abort when neither side has moved for too long
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid === 1'b1 && s_tready === 1'b1) ||
                (m_tvalid === 1'b1 && m_tready === 1'b1) || aresetn !== 1'b1)
                quiet = 0;
            else
                quiet++;
        end
        $display("tb_top failed");
        $finish;
    end

    initial begin : main
        dec_limits[CFG_TIMEOUT]   = TIMEOUT_RST;
        dec_limits[CFG_GLITCH]    = GLITCH_RST;
        dec_limits[CFG_RESP_LOW]  = RESP_LOW_RST;
        dec_limits[CFG_RESP_HIGH] = RESP_HIGH_RST;
        dec_limits[CFG_SHORT]     = SHORT_RST;
        dec_limits[CFG_BIT_LOW]   = BIT_LOW_RST;
        dec_limits[CFG_BIT_HIGH]  = BIT_HIGH_RST;
        dec_limits[CFG_ONE_THR]   = ONE_THR_RST;
        dec_phase   = PH_STOPPED;
        dec_mark    = '0;
        dec_bytes   = '{default: 8'h00};
        dec_bitpos  = TOP_BIT;
        dec_byteidx = '0;
        dec_status  = ST_NOTSTART;
        dec_hum     = '0;
        dec_temp    = '0;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_idle_and_refusal();
        test_response_window();
        test_data_window();
        test_random_frames(160, 1'b0);
        test_extreme_limits();
        test_random_frames(160, 1'b0);
        test_random_frames(160, 1'b1);

        settle();
        if (report_errors == 0 && pending_reports.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

// ----- dht11_edge_timing_decoder_core.f -----
hw/rtl/dhtd_pkg.sv
hw/rtl/dhtd_front.sv
hw/rtl/dhtd_queue.sv
hw/rtl/dhtd_exec.sv
hw/rtl/dht11_edge_timing_decoder_core.sv
verif/tb_top.sv
